FILE: hw/rtl/scl_pkg.sv
// Shared types, constants and helper functions of the streaming conv2d line buffer.
`timescale 1ns / 1ps

package scl_pkg;

  // Geometry
  localparam int IMAGE_WIDTH = 64;
  localparam int KERNEL_SIZE = 3;
  localparam int CHANNELS    = 4;
  localparam int FILTERS     = 4;

  localparam int LINES  = KERNEL_SIZE - 1;
  localparam int ADDR_W = $clog2(IMAGE_WIDTH);
  localparam int LSEL_W = (LINES > 1) ? $clog2(LINES) : 1;
  // channel sum never exceeds CHANNELS*255
  localparam int CUR_W  = $clog2(CHANNELS * 255 + 1);
  localparam int SUM_W  = 16;
  localparam int POS_W  = 7;
  localparam int PH_W   = 4;
  localparam int FIDX_W = 2;
  localparam int CIDX_W = 3;
  localparam int CFG_W  = 8;

  localparam logic [7:0] GRID_MAX = 8'd128;

  // Item commands
  localparam logic CMD_SCAN   = 1'b0;
  localparam logic CMD_WEIGHT = 1'b1;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_STRIDE_ROWS = 3'd0;
  localparam logic [CIDX_W-1:0] REG_STRIDE_COLS = 3'd1;
  localparam logic [CIDX_W-1:0] REG_PAD_AMOUNT  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_GRID_WIDTH  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_GRID_HEIGHT = 3'd4;
  localparam logic [CIDX_W-1:0] REG_CLAMP_LOW   = 3'd5;
  localparam logic [CIDX_W-1:0] REG_CLAMP_HIGH  = 3'd6;

  // Register reset values
  localparam logic [3:0] RST_STRIDE_ROWS = 4'd1;
  localparam logic [3:0] RST_STRIDE_COLS = 4'd1;
  localparam logic [2:0] RST_PAD_AMOUNT  = 3'd1;
  localparam logic [7:0] RST_GRID_WIDTH  = 8'd66;
  localparam logic [7:0] RST_GRID_HEIGHT = 8'd66;
  localparam logic [7:0] RST_CLAMP_LOW   = 8'd0;
  localparam logic [7:0] RST_CLAMP_HIGH  = 8'd255;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_ch0;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch2;
    logic [7:0] pixel_ch3;
    logic [1:0] weight_filter;
    logic [1:0] weight_row;
    logic [1:0] weight_col;
    logic [7:0] weight_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] filter_index;
    logic [7:0] conv_value;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [3:0] stride_rows;
    logic [3:0] stride_cols;
    logic [2:0] pad_amount;
    logic [7:0] grid_width;
    logic [7:0] grid_height;
    logic [7:0] clamp_low;
    logic [7:0] clamp_high;
  } cfg_t;

  // Where the scan stands for the position about to be taken
  typedef struct packed {
    logic              emit;
    logic              in_image;
    logic              col_in;
    logic [ADDR_W-1:0] addr;
    logic [LSEL_W-1:0] oldest;
  } scan_pos_t;

  typedef logic [LINES-1:0][CUR_W-1:0] line_word_t;
  typedef logic [FILTERS-1:0][7:0]     conv_vec_t;

  function automatic logic [PH_W-1:0] start_phase(input logic [3:0] stride,
                                                  input logic [2:0] pad);
    return stride - {1'b0, pad};
  endfunction

  function automatic logic [PH_W-1:0] next_phase(input logic [PH_W-1:0] p,
                                                 input logic [3:0] stride);
    return (p == stride - 4'd1) ? '0 : p + 4'd1;
  endfunction

  function automatic logic [7:0] grid_limit(input logic [7:0] g);
    return (g == 8'd0 || g > GRID_MAX) ? GRID_MAX : g;
  endfunction

  function automatic logic [LSEL_W-1:0] next_line(input logic [LSEL_W-1:0] l);
    return (32'(l) + 1 >= LINES) ? '0 : l + LSEL_W'(1);
  endfunction

endpackage

FILE: hw/rtl/scl_line_mem.sv
// Line store: one entry per image column holding every stored line, read-modify-write.
`timescale 1ns / 1ps

module scl_line_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [scl_pkg::ADDR_W-1:0]   rd_addr,
  output scl_pkg::line_word_t          rd_data,
  input  logic                         wr_en,
  input  logic [scl_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [scl_pkg::LSEL_W-1:0]   wr_sel,
  input  logic [scl_pkg::CUR_W-1:0]    wr_value
);

  scl_pkg::line_word_t mem [scl_pkg::IMAGE_WIDTH];
  logic [scl_pkg::IMAGE_WIDTH-1:0] valid;

  scl_pkg::line_word_t mem_q;
  logic                vld_q;
  logic                byp_q;
  scl_pkg::line_word_t byp_data;
  scl_pkg::line_word_t merged;

  // new column word: the entry read for this item with the oldest line replaced
  always_comb begin
    merged = rd_data;
    merged[wr_sel] = wr_value;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // registered read; a write to the same entry in the read cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      vld_q    <= valid[rd_addr];
      byp_q    <= wr_en && (wr_addr == rd_addr);
      byp_data <= merged;
    end
  end

  assign rd_data = byp_q ? byp_data : (vld_q ? mem_q : '0);

endmodule

FILE: hw/rtl/scl_scan_ctrl.sv
// Scan position, stride phase and line rotation counters.
`timescale 1ns / 1ps

module scl_scan_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  scl_pkg::cfg_t        cfg,
  output scl_pkg::scan_pos_t   pos
);

  logic [scl_pkg::POS_W-1:0]  row;
  logic [scl_pkg::POS_W-1:0]  col;
  logic [scl_pkg::PH_W-1:0]   row_phase;
  logic [scl_pkg::PH_W-1:0]   col_phase;
  logic [scl_pkg::LSEL_W-1:0] oldest;

  logic col_end;
  logic row_end;

  assign col_end = ({1'b0, col} + 8'd1) >= scl_pkg::grid_limit(cfg.grid_width);
  assign row_end = ({1'b0, row} + 8'd1) >= scl_pkg::grid_limit(cfg.grid_height);

  always_comb begin
    pos.col_in   = 32'(col) < scl_pkg::IMAGE_WIDTH;
    pos.in_image = pos.col_in && (32'(row) < scl_pkg::IMAGE_WIDTH);
    pos.emit     = (row >= {4'd0, cfg.pad_amount}) && (col >= {4'd0, cfg.pad_amount}) &&
                   (row_phase == '0) && (col_phase == '0);
    pos.addr     = scl_pkg::ADDR_W'(col);
    pos.oldest   = oldest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      oldest    <= '0;
      row_phase <= scl_pkg::start_phase(scl_pkg::RST_STRIDE_ROWS, scl_pkg::RST_PAD_AMOUNT);
      col_phase <= scl_pkg::start_phase(scl_pkg::RST_STRIDE_COLS, scl_pkg::RST_PAD_AMOUNT);
    end else if (step) begin
      if (col_end) begin
        col       <= '0;
        col_phase <= scl_pkg::start_phase(cfg.stride_cols, cfg.pad_amount);
        if (row_end) begin
          row       <= '0;
          oldest    <= '0;
          row_phase <= scl_pkg::start_phase(cfg.stride_rows, cfg.pad_amount);
        end else begin
          row       <= row + 7'd1;
          oldest    <= scl_pkg::next_line(oldest);
          row_phase <= scl_pkg::next_phase(row_phase, cfg.stride_rows);
        end
      end else begin
        col       <= col + 7'd1;
        col_phase <= scl_pkg::next_phase(col_phase, cfg.stride_cols);
      end
    end
  end

endmodule

FILE: hw/rtl/scl_filter_bank.sv
// Kernel weights, per-filter column MACs, partial sum chain and clamp.
`timescale 1ns / 1ps

module scl_filter_bank (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  scl_pkg::line_word_t         lines,
  input  logic [scl_pkg::LSEL_W-1:0]  oldest,
  input  logic                        col_in,
  input  logic [scl_pkg::CUR_W-1:0]   cur,
  input  logic                        kern_we,
  input  logic [1:0]                  kern_filter,
  input  logic [1:0]                  kern_row,
  input  logic [1:0]                  kern_col,
  input  logic [7:0]                  kern_value,
  input  logic [7:0]                  clamp_low,
  input  logic [7:0]                  clamp_high,
  output scl_pkg::conv_vec_t          conv
);

  localparam int K  = scl_pkg::KERNEL_SIZE;
  localparam int L  = scl_pkg::LINES;
  localparam int NF = scl_pkg::FILTERS;
  localparam int SW = scl_pkg::SUM_W;

  logic [7:0]    kern   [NF][K][K];
  logic [SW-1:0] ps     [NF][L];
  logic [SW-1:0] colsum [NF][K];
  logic [SW-1:0] res    [NF];
  logic [scl_pkg::CUR_W-1:0] line_rot [L];

  // kernel row kr pairs with the kr-th oldest stored line
  always_comb begin
    int p;
    for (int kr = 0; kr < L; kr++) begin
      p = 32'(oldest) + kr;
      if (p >= L) p = p - L;
      line_rot[kr] = lines[p];
    end
  end

  always_comb begin
    for (int f = 0; f < NF; f++) begin
      for (int kc = 0; kc < K; kc++) begin
        colsum[f][kc] = '0;
        if (col_in) begin
          for (int kr = 0; kr < L; kr++) begin
            colsum[f][kc] = colsum[f][kc] + SW'(line_rot[kr]) * SW'(kern[f][kr][kc]);
          end
          colsum[f][kc] = colsum[f][kc] + SW'(cur) * SW'(kern[f][L][kc]);
        end
      end
      res[f] = colsum[f][K-1] + ps[f][L-1];
      if (res[f] < {8'd0, clamp_low}) begin
        conv[f] = clamp_low;
      end else if (res[f] > {8'd0, clamp_high}) begin
        conv[f] = clamp_high;
      end else begin
        conv[f] = res[f][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (kern_we && 32'(kern_filter) < NF && 32'(kern_row) < K && 32'(kern_col) < K) begin
      kern[kern_filter][kern_row][kern_col] <= kern_value;
    end
  end

  // window sum finishes at the current column; older columns wait in the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < NF; f++) begin
        for (int k = 0; k < L; k++) begin
          ps[f][k] <= '0;
        end
      end
    end else if (advance) begin
      for (int f = 0; f < NF; f++) begin
        ps[f][0] <= colsum[f][0];
        for (int k = 1; k < L; k++) begin
          ps[f][k] <= ps[f][k-1] + colsum[f][k];
        end
      end
    end
  end

endmodule

FILE: hw/rtl/scl_result_ser.sv
// Result buffer that hands out one filter word per cycle while out_ready is high.
`timescale 1ns / 1ps

module scl_result_ser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  scl_pkg::conv_vec_t   vals,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scl_pkg::out_word_t   out_data
);

  localparam logic [scl_pkg::FIDX_W-1:0] LAST_IDX = scl_pkg::FIDX_W'(scl_pkg::FILTERS - 1);

  scl_pkg::conv_vec_t        buf_vals;
  logic [scl_pkg::FIDX_W-1:0] idx;
  logic                       busy;
  logic                       is_last;

  assign is_last   = idx == LAST_IDX;
  assign out_valid = busy;
  assign free      = !busy || (out_ready && is_last);

  always_comb begin
    out_data.filter_index = idx;
    out_data.conv_value   = buf_vals[idx];
    out_data.last         = is_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_vals <= vals;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + scl_pkg::FIDX_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/stream_conv2d_line_buffer.sv
// Top level of the streaming multi-filter 2-D convolution with line store.
`timescale 1ns / 1ps

// Streaming 3x3 convolution over a padded scan grid, four filters in parallel.
// Each item is either one scan position (cmd 0, four 8-bit channel pixels that
// are summed inside the image) or a kernel weight write (cmd 1, no result).
// Timing: an item is taken every cycle as long as no result waits for a busy
// result buffer; a position on the stride grid produces one word per filter,
// and those words leave one per cycle through the single result port while
// result_ready is high, so a position that emits waits in the MAC stage until
// the last word of the one before it leaves. The first word of a position is
// offered once the MAC stage loads the result buffer, which waits until the
// buffer is free. Pipeline: the scan counters and the read of the line store
// happen at accept; the MAC stage then multiplies the column against
// all kernels, moves the partial sum chain, clamps, and writes the current
// value back into the oldest line of that column. The line store is one 64-entry
// memory of two 10-bit lines per column, one read and one write a cycle, with
// write-to-read forwarding for a one-column grid. It is cleared at reset by
// per-entry valid bits (no clearing pass, usable at once) and keeps its
// contents between frames. Weights must be written before they are used.
// Registers (cfg_index): 0 stride_rows, 1 stride_cols, 2 pad_amount,
// 3 grid_width, 4 grid_height, 5 clamp_low, 6 clamp_high; write them only
// while the block is idle. Grid sizes of 0 or above 128 act as 128.

module stream_conv2d_line_buffer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  scl_pkg::in_word_t            item_data,
  output logic                         result_valid,
  input  logic                         result_ready,
  output scl_pkg::out_word_t           result_data,
  input  logic                         cfg_write,
  input  logic [scl_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [scl_pkg::CFG_W-1:0]    cfg_data
);

  scl_pkg::cfg_t      cfg;
  scl_pkg::scan_pos_t pos;

  logic item_accept;
  logic scan_accept;
  logic weight_write;

  // scan item in the MAC stage
  logic                       s1_valid;
  logic                       s1_emit;
  logic                       s1_col_in;
  logic [scl_pkg::ADDR_W-1:0] s1_addr;
  logic [scl_pkg::LSEL_W-1:0] s1_oldest;
  logic [scl_pkg::CUR_W-1:0]  s1_cur;
  logic                       s1_adv;

  logic [scl_pkg::CUR_W-1:0]  cur;
  logic [7:0]                 pix [4];
  scl_pkg::line_word_t        lines;
  scl_pkg::conv_vec_t         conv;
  logic                       ser_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stride_rows <= scl_pkg::RST_STRIDE_ROWS;
      cfg.stride_cols <= scl_pkg::RST_STRIDE_COLS;
      cfg.pad_amount  <= scl_pkg::RST_PAD_AMOUNT;
      cfg.grid_width  <= scl_pkg::RST_GRID_WIDTH;
      cfg.grid_height <= scl_pkg::RST_GRID_HEIGHT;
      cfg.clamp_low   <= scl_pkg::RST_CLAMP_LOW;
      cfg.clamp_high  <= scl_pkg::RST_CLAMP_HIGH;
    end else if (cfg_write) begin
      case (cfg_index)
        scl_pkg::REG_STRIDE_ROWS: cfg.stride_rows <= cfg_data[3:0];
        scl_pkg::REG_STRIDE_COLS: cfg.stride_cols <= cfg_data[3:0];
        scl_pkg::REG_PAD_AMOUNT:  cfg.pad_amount  <= cfg_data[2:0];
        scl_pkg::REG_GRID_WIDTH:  cfg.grid_width  <= cfg_data;
        scl_pkg::REG_GRID_HEIGHT: cfg.grid_height <= cfg_data;
        scl_pkg::REG_CLAMP_LOW:   cfg.clamp_low   <= cfg_data;
        scl_pkg::REG_CLAMP_HIGH:  cfg.clamp_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // MAC stage moves on unless it must hand words to a busy result buffer
  assign s1_adv       = s1_valid && (!s1_emit || ser_free);
  assign item_ready   = !s1_valid || s1_adv;
  assign item_accept  = item_valid && item_ready;
  assign scan_accept  = item_accept && (item_data.cmd == scl_pkg::CMD_SCAN);
  assign weight_write = item_accept && (item_data.cmd == scl_pkg::CMD_WEIGHT);

  // channel sum, zero outside the image
  always_comb begin
    pix[0] = item_data.pixel_ch0;
    pix[1] = item_data.pixel_ch1;
    pix[2] = item_data.pixel_ch2;
    pix[3] = item_data.pixel_ch3;
    cur = '0;
    if (pos.in_image) begin
      for (int k = 0; k < scl_pkg::CHANNELS; k++) begin
        cur = cur + scl_pkg::CUR_W'(pix[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_accept) begin
      s1_emit   <= pos.emit;
      s1_col_in <= pos.col_in;
      s1_addr   <= pos.addr;
      s1_oldest <= pos.oldest;
      s1_cur    <= cur;
    end
  end

  scl_scan_ctrl u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (scan_accept),
    .cfg  (cfg),
    .pos  (pos)
  );

  scl_line_mem u_lines (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (scan_accept),
    .rd_addr  (pos.addr),
    .rd_data  (lines),
    .wr_en    (s1_adv && s1_col_in),
    .wr_addr  (s1_addr),
    .wr_sel   (s1_oldest),
    .wr_value (s1_cur)
  );

  scl_filter_bank u_filters (
    .clk         (clk),
    .rst         (rst),
    .advance     (s1_adv),
    .lines       (lines),
    .oldest      (s1_oldest),
    .col_in      (s1_col_in),
    .cur         (s1_cur),
    .kern_we     (weight_write),
    .kern_filter (item_data.weight_filter),
    .kern_row    (item_data.weight_row),
    .kern_col    (item_data.weight_col),
    .kern_value  (item_data.weight_value),
    .clamp_low   (cfg.clamp_low),
    .clamp_high  (cfg.clamp_high),
    .conv        (conv)
  );

  scl_result_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && s1_emit),
    .vals      (conv),
    .free      (ser_free),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result_data)
  );

endmodule
